@@ src/bds_pkg.sv @@
// Package for the brush dab spacing block: widths, defaults and codes.
// Used by brush_dab_spacing; depends on nothing.
package bds_pkg;
  localparam int COORD_BITS_DEF = 12;
  localparam int MAX_DABS_DEF   = 64;
  localparam int SPACING_W      = 12;
  localparam int BRUSH_W        = 8;
  localparam int OUT_W          = 13;
  localparam int SPACING_MIN    = 16;
  localparam logic [SPACING_W-1:0] SPACING_RST = SPACING_W'(32);
  localparam logic [BRUSH_W-1:0]   BRUSH_RST   = BRUSH_W'(17);
  localparam int CFG_IDX_W      = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SPACING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 2'd2;
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_MOVE  = 1'b1;
endpackage

@@ src/bds_serdiv.sv @@
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
// Depends on nothing; used by brush_dab_spacing.
module bds_serdiv #(
  parameter int NW = 32,
  parameter int DW = 20
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   r_r, r_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [DW:0]   trial;

  always_comb begin
    q_nxt = q_r; r_nxt = r_r; d_nxt = d_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {r_r[DW-1:0], q_r[NW-1]};
    if (start) begin
      q_nxt = num; r_nxt = '0; d_nxt = den; cnt_nxt = CW'(NW); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        r_nxt = trial - {1'b0, d_r};
        q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        r_nxt = trial;
        q_nxt = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt; r_r <= r_nxt; d_r <= d_nxt; cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quo  = q_r;
  assign rem  = r_r[DW-1:0];
endmodule

@@ src/brush_dab_spacing.sv @@
// Top level of the brush dab spacing block: sequencer, square root and stamp loop.
// Depends on bds_pkg and bds_serdiv.
//
//  Channel | Direction | Beat contents
//  in_     | in        | tdata {point_y, point_x}, tuser command
//  out_    | out       | tdata {6'b0, dab_y, dab_x}, tlast last_dab, tuser overflow
//  cfg_    | in        | index, data
//
// A start beat is taken and the block is ready again at once. A move beat forms the radicand,
// takes the square root one result bit per cycle, and reduces the kept phase in the serial
// divider, whose numerator is NW = 2*COORD_BITS+18 bits wide. A move that reaches a stamp adds
// a division for the stamp count and one division per axis for each stamp, and any move of
// non-zero length ends with one more division for the new phase. Reset is synchronous. A stamp
// beat that the sink does not take holds the loop before the next stamp until it is taken.
module brush_dab_spacing
  import bds_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int MAX_DABS   = MAX_DABS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [2*COORD_BITS-1:0]       in_tdata,  // point_x, point_y
  input  logic                          in_tuser,  // command
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [2*bds_pkg::OUT_W+5:0]   out_tdata, // dab_x, dab_y, zero fill
  output logic                          out_tlast, // last_dab
  output logic                          out_tuser, // overflow
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data
);
  localparam int CB  = COORD_BITS;
  localparam int SQW = 2*CB + 10;          // (dx^2+dy^2)<<8
  localparam int SRW = CB + 5;             // root width
  localparam int PW  = SRW + 1;
  localparam int NW  = 2*SRW + 8;          // t*|d| width, covers count numerator
  localparam int DW  = SRW;
  localparam int SC  = $clog2(SRW + 1);
  localparam int KW  = $clog2(MAX_DABS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_ROOT, S_CNT, S_CNTW, S_DIVX, S_DIVXW, S_DIVY, S_DIVYW,
    S_OUT, S_PH, S_PHW
  } state_t;
  state_t state_r;

  logic [SPACING_W-1:0] spacing_r;
  logic [BRUSH_W-1:0]   bw_r, bh_r;
  logic [CB-1:0]        last_x_r, last_y_r, px_r, py_r;
  logic [15:0]          phase_r;
  logic [SQW-1:0]       rad_r;
  logic [SRW-1:0]       root_r;
  logic [SRW+1:0]       rem_r;
  logic [SC-1:0]        rcnt_r;
  logic [CB-1:0]        adx_r, ady_r;
  logic                 sx_r, sy_r;
  logic [PW-1:0]        t_r;
  logic [PW-1:0]        sp_r, ph_r;
  logic [KW-1:0]        emit_r, k_r;
  logic                 ovf_r;
  logic [CB:0]          ix_r, iy_r;
  logic [OUT_W-1:0]     ox_r, oy_r;
  logic                 olast_r, oovf_r, ovalid_r;
  logic                 phase_wait_r;

  logic          dv_start;
  logic [NW-1:0] dv_num, dv_quo;
  logic [DW-1:0] dv_den, dv_rem;
  logic          dv_done;

  bds_serdiv #(.NW(NW), .DW(DW)) u_div (
    .clk, .rst_n, .start(dv_start), .num(dv_num), .den(dv_den),
    .done(dv_done), .quo(dv_quo), .rem(dv_rem)
  );

  logic [CB:0]  dxs, dys;
  logic [SRW+1:0] trial;
  logic [SRW+1:0] rem_sh;
  logic [NW-1:0]  prodx, prody;
  logic [SRW:0]   ptot;

  assign dxs    = {1'b0, px_r} - {1'b0, last_x_r};
  assign dys    = {1'b0, py_r} - {1'b0, last_y_r};
  assign rem_sh = {rem_r[SRW-1:0], rad_r[SQW-1 -: 2]};
  assign trial  = {root_r, 2'b01};
  assign prodx  = NW'(t_r) * NW'(adx_r);
  assign prody  = NW'(t_r) * NW'(ady_r);
  assign ptot   = ph_r + {1'b0, root_r};

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = (state_r == S_IDLE) && !in_tvalid;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {6'b0, oy_r, ox_r};
  assign out_tlast  = olast_r;
  assign out_tuser  = oovf_r;

  // Floor of signed quotient: negative axis rounds away from zero when inexact.
  function automatic logic [CB:0] axis_pos(input logic [CB-1:0] base, input logic neg,
                                           input logic [NW-1:0] q, input logic inexact);
    logic [CB:0] qq;
    qq = (CB+1)'(q);
    if (neg) axis_pos = {1'b0, base} - qq - (CB+1)'(inexact);
    else     axis_pos = {1'b0, base} + qq;
  endfunction

  always_comb begin
    dv_start = 1'b0; dv_num = '0; dv_den = root_r;
    case (state_r)
      S_CNT: begin
        dv_start = 1'b1; dv_num = NW'(root_r - SRW'(sp_r - ph_r)); dv_den = DW'(sp_r);
      end
      S_DIVX: begin dv_start = 1'b1; dv_num = prodx; end
      S_DIVY: begin dv_start = 1'b1; dv_num = prody; end
      // Old phase when reducing it, else phase plus distance moved.
      S_PH: begin
        dv_start = 1'b1; dv_den = DW'(sp_r);
        dv_num = phase_wait_r ? NW'(phase_r) : NW'(ptot);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; spacing_r <= SPACING_RST; bw_r <= BRUSH_RST; bh_r <= BRUSH_RST;
      last_x_r <= '0; last_y_r <= '0; phase_r <= '0; ovalid_r <= 1'b0;
      phase_wait_r <= 1'b0;
    end else begin
      if (ovalid_r && out_tready && state_r != S_OUT) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            case (cfg_index)
              REG_SPACING: spacing_r <= cfg_data[SPACING_W-1:0];
              REG_WIDTH:   bw_r <= cfg_data[BRUSH_W-1:0];
              REG_HEIGHT:  bh_r <= cfg_data[BRUSH_W-1:0];
              default: ;
            endcase
          end
          if (in_tvalid) begin
            px_r <= in_tdata[CB-1:0]; py_r <= in_tdata[2*CB-1:CB];
            if (in_tuser == CMD_START) begin
              last_x_r <= in_tdata[CB-1:0]; last_y_r <= in_tdata[2*CB-1:CB];
            end else begin
              sp_r <= (spacing_r < SPACING_W'(SPACING_MIN)) ? PW'(SPACING_MIN) : PW'(spacing_r);
              state_r <= S_SQ;
            end
          end
        end
        S_SQ: begin
          // Magnitudes and signs of the axis steps, and the radicand for the root.
          sx_r <= dxs[CB]; sy_r <= dys[CB];
          adx_r <= dxs[CB] ? CB'(-dxs) : dxs[CB-1:0];
          ady_r <= dys[CB] ? CB'(-dys) : dys[CB-1:0];
          rad_r <= SQW'(({{(CB+1){1'b0}}, (dxs[CB] ? CB'(-dxs) : dxs[CB-1:0])}
                         * {{(CB+1){1'b0}}, (dxs[CB] ? CB'(-dxs) : dxs[CB-1:0])})
                     + ({{(CB+1){1'b0}}, (dys[CB] ? CB'(-dys) : dys[CB-1:0])}
                         * {{(CB+1){1'b0}}, (dys[CB] ? CB'(-dys) : dys[CB-1:0])})) << 8;
          root_r <= '0; rem_r <= '0; rcnt_r <= SC'(SQW/2);
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          // One root bit per cycle from two radicand bits.
          rad_r <= {rad_r[SQW-3:0], 2'b00};
          if (rem_sh >= trial) begin
            rem_r <= rem_sh - trial; root_r <= {root_r[SRW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh; root_r <= {root_r[SRW-2:0], 1'b0};
          end
          rcnt_r <= rcnt_r - SC'(1);
          if (rcnt_r == SC'(1)) begin
            state_r <= S_PH; phase_wait_r <= 1'b1;
          end
        end
        S_PH: begin
          // First pass reduces the old phase, second forms the new one.
          state_r <= S_PHW;
        end
        S_PHW: begin
          if (dv_done) begin
            if (phase_wait_r) begin
              phase_wait_r <= 1'b0;
              ph_r <= PW'(dv_rem);
              if (root_r == '0) begin
                phase_r <= 16'(dv_rem); last_x_r <= px_r; last_y_r <= py_r;
                state_r <= S_IDLE;
              end else if (SRW'(sp_r) - SRW'(dv_rem) > root_r) begin
                emit_r <= '0; state_r <= S_PH;
              end else state_r <= S_CNT;
            end else begin
              phase_r <= 16'(dv_rem); last_x_r <= px_r; last_y_r <= py_r;
              state_r <= S_IDLE;
            end
          end
        end
        S_CNT: state_r <= S_CNTW;
        S_CNTW: begin
          if (dv_done) begin
            if (dv_quo >= NW'(MAX_DABS)) begin
              emit_r <= KW'(MAX_DABS); ovf_r <= (dv_quo != NW'(MAX_DABS - 1));
            end else begin
              emit_r <= KW'(dv_quo + NW'(1)); ovf_r <= 1'b0;
            end
            k_r <= '0; t_r <= sp_r - ph_r; state_r <= S_DIVX;
          end
        end
        S_DIVX: state_r <= S_DIVXW;
        S_DIVXW: if (dv_done) begin
          ix_r <= axis_pos(last_x_r, sx_r, dv_quo, dv_rem != '0); state_r <= S_DIVY;
        end
        S_DIVY: state_r <= S_DIVYW;
        S_DIVYW: if (dv_done) begin
          iy_r <= axis_pos(last_y_r, sy_r, dv_quo, dv_rem != '0);
          state_r <= S_OUT;
        end
        S_OUT: begin
          // The output register is loaded only once the previous beat has gone.
          if (!ovalid_r || out_tready) begin
            ovalid_r <= 1'b1;
            ox_r <= OUT_W'(ix_r) - OUT_W'(bw_r >> 1);
            oy_r <= OUT_W'(iy_r) - OUT_W'(bh_r >> 1);
            olast_r <= (k_r == emit_r - KW'(1));
            oovf_r  <= (k_r == emit_r - KW'(1)) && ovf_r;
            if (k_r == emit_r - KW'(1)) state_r <= S_PH;
            else begin
              k_r <= k_r + KW'(1); t_r <= t_r + sp_r; state_r <= S_DIVX;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
